// File: design/mst_pkg.sv
// Shared types and codes for the multi-channel software timer.
// Used by mst_cell, multi_channel_software_timer and the testbench; no dependencies.
package mst_pkg;

  localparam int DEF_NUM_TIMERS = 16;
  localparam int CMD_W          = 3;
  localparam int ID_W           = 4;
  localparam int VAL_W          = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

  // result kinds
  localparam logic [CMD_W-1:0] KIND_EXPIRY = 3'd0;
  localparam logic [CMD_W-1:0] KIND_START  = 3'd1;
  localparam logic [CMD_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [CMD_W-1:0] KIND_LEFT   = 3'd3;
  localparam logic [CMD_W-1:0] KIND_UPTIME = 3'd4;
  localparam logic [CMD_W-1:0] KIND_CLEAR  = 3'd5;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             shift;    // token moves one cell
    logic             walk;     // tick scan in progress
    logic             advance;  // scan step taken this cycle
    logic             start_en;
    logic             stop_en;
    logic [ID_W-1:0]  tgt;
    logic [VAL_W-1:0] timeout;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] uptime;
  } ctl_t;

  // status returned by each cell
  typedef struct packed {
    logic             hit;
    logic             sel_running;
    logic [VAL_W-1:0] sel_left;
  } stat_t;

endpackage

// File: design/mst_cell.sv
// One timer cell: deadline, reload period, running flag and a scan token.
// Depends on mst_pkg.
module mst_cell #(
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  mst_pkg::ctl_t  ctl,
  input  logic           tok_in,
  output logic           tok_out,
  output mst_pkg::stat_t stat
);
  import mst_pkg::*;

  logic [VAL_W-1:0] deadline;
  logic [VAL_W-1:0] reload_period;
  logic             running;
  logic             tok;
  logic             addressed;
  logic             hit;
  logic             do_start;

  assign addressed = (32'(ctl.tgt) == 32'(INDEX));
  assign hit       = tok && ctl.walk && running && (deadline == ctl.uptime);
  assign do_start  = ctl.start_en && addressed && !running && (ctl.timeout != '0);
  assign tok_out   = tok;

  assign stat.hit         = hit;
  assign stat.sel_running = addressed && running;
  assign stat.sel_left    = (addressed && running) ? (deadline - ctl.uptime) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= 1'b0;
      running <= 1'b0;
    end else begin
      if (ctl.shift) begin
        tok <= tok_in;
      end
      if (do_start) begin
        running <= 1'b1;
      end else if (ctl.stop_en && addressed) begin
        running <= 1'b0;
      end else if (hit && ctl.advance && (reload_period == '0)) begin
        running <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (do_start) begin
      deadline      <= ctl.uptime + ctl.timeout + VAL_W'(1);
      reload_period <= ctl.period;
    end else if (hit && ctl.advance && (reload_period != '0)) begin
      deadline <= ctl.uptime + reload_period;
    end
  end

endmodule

// File: design/multi_channel_software_timer.sv
// Multi-channel software timer: uptime counter and a chain of timer cells.
// Start, stop, time left, uptime read and clear: result registered.
// Tick: a token walks the chain one cell per cycle while no second expiry waits
// on a stalled output; one item is in work at a time.
// Synchronous active-high reset clears uptime, running flags and control.
// Depends on mst_pkg and mst_cell.
module multi_channel_software_timer #(
  parameter int NUM_TIMERS = mst_pkg::DEF_NUM_TIMERS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  logic [mst_pkg::CMD_W-1:0] cmd,
  input  logic [mst_pkg::ID_W-1:0]  timer_id,
  input  logic [mst_pkg::VAL_W-1:0] timeout,
  input  logic [mst_pkg::VAL_W-1:0] period,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [mst_pkg::CMD_W-1:0] kind,
  output logic [mst_pkg::ID_W-1:0]  timer_id_res,
  output logic                      accepted,
  output logic [mst_pkg::VAL_W-1:0] value,
  output logic                      last
);
  import mst_pkg::*;

  localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state;
  logic [VAL_W-1:0] uptime;
  logic [PW-1:0]    pos;        // cell holding the token
  logic             pend_valid; // expiry found, not yet sent (last unknown)
  logic [ID_W-1:0]  pend_id;

  ctl_t             ctl;
  stat_t            stat [NUM_TIMERS];
  logic [NUM_TIMERS:0] tok_chain;

  logic             out_free;
  logic             acc_in;
  logic             id_ok;
  logic             hit;
  logic             sel_running;
  logic [VAL_W-1:0] sel_left;
  logic             step;
  logic             is_tick;

  // result load
  logic             ld;
  logic [CMD_W-1:0] ld_kind;
  logic [ID_W-1:0]  ld_id;
  logic             ld_acc;
  logic [VAL_W-1:0] ld_value;
  logic             ld_last;

  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE) && out_free;
  assign acc_in    = cmd_valid && cmd_ready;
  assign is_tick   = (cmd == CMD_TICK);
  assign id_ok     = ({{(32-ID_W){1'b0}}, timer_id} < 32'(NUM_TIMERS));

  // only the token cell can hit; only the addressed cell reports status
  always_comb begin
    hit         = 1'b0;
    sel_running = 1'b0;
    sel_left    = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      hit         = hit | stat[i].hit;
      sel_running = sel_running | stat[i].sel_running;
      sel_left    = sel_left | stat[i].sel_left;
    end
  end

  // a second expiry needs the pending one sent first
  assign step = !(hit && pend_valid && !out_free);

  always_comb begin
    ctl.walk     = (state == ST_WALK);
    ctl.advance  = (state == ST_WALK) && step;
    ctl.shift    = (acc_in && is_tick) || ((state == ST_WALK) && step);
    ctl.start_en = acc_in && (cmd == CMD_START);
    ctl.stop_en  = acc_in && (cmd == CMD_STOP);
    ctl.tgt      = timer_id;
    ctl.timeout  = timeout;
    ctl.period   = period;
    ctl.uptime   = uptime;
  end

  assign tok_chain[0] = acc_in && is_tick;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    mst_cell #(.INDEX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .tok_in  (tok_chain[g]),
      .tok_out (tok_chain[g+1]),
      .stat    (stat[g])
    );
  end

  // result selection
  always_comb begin
    ld       = 1'b0;
    ld_kind  = KIND_EXPIRY;
    ld_id    = '0;
    ld_acc   = 1'b0;
    ld_value = '0;
    ld_last  = 1'b1;
    case (state)
      ST_IDLE: begin
        if (acc_in) begin
          case (cmd)
            CMD_START: begin
              ld      = 1'b1;
              ld_kind = KIND_START;
              ld_id   = timer_id;
              ld_acc  = id_ok && !sel_running && (timeout != '0);
            end
            CMD_STOP: begin
              ld      = 1'b1;
              ld_kind = KIND_STOP;
              ld_id   = timer_id;
            end
            CMD_LEFT: begin
              ld       = 1'b1;
              ld_kind  = KIND_LEFT;
              ld_id    = timer_id;
              ld_value = sel_left;
            end
            CMD_READ: begin
              ld       = 1'b1;
              ld_kind  = KIND_UPTIME;
              ld_value = uptime;
            end
            CMD_CLEAR: begin
              ld      = 1'b1;
              ld_kind = KIND_CLEAR;
            end
            default: ld = 1'b0;
          endcase
        end
      end
      ST_WALK: begin
        if (step && hit && pend_valid) begin
          ld      = 1'b1;
          ld_id   = pend_id;
          ld_last = 1'b0;
        end
      end
      ST_FLUSH: begin
        if (pend_valid && out_free) begin
          ld    = 1'b1;
          ld_id = pend_id;
        end
      end
      default: ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      uptime     <= '0;
      pos        <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      // a new load wins over the transfer of the old result
      if (ld) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc_in && is_tick) begin
            uptime     <= uptime + VAL_W'(1);
            pos        <= '0;
            pend_valid <= 1'b0;
            state      <= ST_WALK;
          end else if (acc_in && (cmd == CMD_CLEAR)) begin
            uptime <= '0;
          end
        end
        ST_WALK: begin
          if (step) begin
            pos <= pos + PW'(1);
            if (hit) begin
              pend_valid <= 1'b1;
              pend_id    <= ID_W'(pos);
            end
            if (tok_chain[NUM_TIMERS]) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output payload, no reset
  always_ff @(posedge clk) begin
    if (ld) begin
      kind         <= ld_kind;
      timer_id_res <= ld_id;
      accepted     <= ld_acc;
      value        <= ld_value;
      last         <= ld_last;
    end
  end

endmodule

// File: test/tb_multi_channel_software_timer.sv
// Testbench for multi_channel_software_timer: directed and random command streams
// with a cycle-accurate-free transfer-level predictor and in-order result checks.
// Depends on mst_pkg and the timer RTL; stands alone otherwise.
module tb_multi_channel_software_timer;
  timeunit 1ns;
  timeprecision 1ps;

  import mst_pkg::*;

  localparam int NT           = DEF_NUM_TIMERS;
  localparam int RANDOM_ITEMS = 360;     // plus the full volley ahead of it
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int MAX_REPORTS  = 10;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // one result transfer as seen on the output channel
  typedef struct packed {
    logic [CMD_W-1:0] kind;
    logic [ID_W-1:0]  id;
    logic             acc;
    logic [VAL_W-1:0] value;
    logic             last;
  } timer_event_t;

  // DUT ports; every input has a known value from time zero
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  logic [CMD_W-1:0] cmd       = '0;
  logic [ID_W-1:0]  timer_id  = '0;
  logic [VAL_W-1:0] timeout   = '0;
  logic [VAL_W-1:0] period    = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  logic [CMD_W-1:0] kind;
  logic [ID_W-1:0]  timer_id_res;
  logic             accepted;
  logic [VAL_W-1:0] value;
  logic             last;

  // predictor state: uptime, per-timer deadline, reload period, running flag
  logic [VAL_W-1:0] clock_now = '0;
  logic [VAL_W-1:0] due_at    [NT];
  logic [VAL_W-1:0] reload_by [NT];
  logic             armed     [NT];

  timer_event_t due_events[$];   // results still owed by the block, oldest first
  int  fault_count = 0;
  int  sent_count  = 0;          // transfers of meaningful commands
  int  cycle_count = 0;
  logic steady     = 1'b0;       // both sides run without idling while set

  multi_channel_software_timer dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .timer_id     (timer_id),
    .timeout      (timeout),
    .period       (period),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .kind         (kind),
    .timer_id_res (timer_id_res),
    .accepted     (accepted),
    .value        (value),
    .last         (last)
  );

  always #4 clk = ~clk;

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("[%0t] %s", $realtime, msg);
  endtask

  function automatic timer_event_t make_event(input logic [CMD_W-1:0] k,
                                              input logic [ID_W-1:0] id,
                                              input logic acc,
                                              input logic [VAL_W-1:0] v,
                                              input logic lst);
    timer_event_t ev;
    ev.kind  = k;
    ev.id    = id;
    ev.acc   = acc;
    ev.value = v;
    ev.last  = lst;
    return ev;
  endfunction

  // Apply one accepted command to the timer bank and queue what it owes.
  function automatic void timer_bank_apply(input logic [CMD_W-1:0] op,
                                           input logic [ID_W-1:0] id,
                                           input logic [VAL_W-1:0] wait_ticks,
                                           input logic [VAL_W-1:0] reload);
    logic [NT-1:0]    hits;
    logic             ok;
    logic [VAL_W-1:0] left;
    hits = '0;
    ok   = 1'b0;
    left = '0;
    case (op)
      CMD_TICK: begin
        clock_now = clock_now + 1;
        // collect all hits first so the last mark lands on the highest one
        for (int i = 0; i < NT; i++)
          if (armed[i] && due_at[i] == clock_now) hits[i] = 1'b1;
        for (int i = 0; i < NT; i++) begin
          if (hits[i]) begin
            due_events.push_back(make_event(KIND_EXPIRY, ID_W'(i), 1'b0, '0,
                                            (hits >> (i + 1)) == '0));
            if (reload_by[i] != 0) due_at[i] = clock_now + reload_by[i];
            else armed[i] = 1'b0;
          end
        end
      end
      CMD_START: begin
        if (!armed[id] && wait_ticks != 0) begin
          due_at[id]    = clock_now + wait_ticks + 1;  // wraps mod 2^32
          reload_by[id] = reload;
          armed[id]     = 1'b1;
          ok            = 1'b1;
        end
        due_events.push_back(make_event(KIND_START, id, ok, '0, 1'b1));
      end
      CMD_STOP: begin
        armed[id] = 1'b0;
        due_events.push_back(make_event(KIND_STOP, id, 1'b0, '0, 1'b1));
      end
      CMD_LEFT: begin
        if (armed[id]) left = due_at[id] - clock_now;
        due_events.push_back(make_event(KIND_LEFT, id, 1'b0, left, 1'b1));
      end
      CMD_READ: due_events.push_back(make_event(KIND_UPTIME, '0, 1'b0, clock_now, 1'b1));
      CMD_CLEAR: begin
        clock_now = '0;
        due_events.push_back(make_event(KIND_CLEAR, '0, 1'b0, '0, 1'b1));
      end
      default: ;  // spare codes: no result, no change
    endcase
  endfunction

  // Command side: random gap, then hold valid and payload until the transfer.
  // Entered and left at a falling edge.
  task automatic send_command(input logic [CMD_W-1:0] op,
                              input logic [ID_W-1:0] id,
                              input logic [VAL_W-1:0] wait_ticks,
                              input logic [VAL_W-1:0] reload);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= op;
    timer_id  <= id;
    timeout   <= wait_ticks;
    period    <= reload;
    do @(posedge clk); while (!cmd_ready);
    timer_bank_apply(op, id, wait_ticks, reload);
    if (op != CMD_SPARE_LO && op != CMD_SPARE_HI) sent_count++;
    @(negedge clk);
  endtask

  // Hold off new commands until every owed result has been seen.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: random stall per transfer, stretches of none while steady.
  initial begin
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        res_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    timer_event_t got;
    timer_event_t want;
    if (!rst && res_valid && res_ready) begin
      got = make_event(kind, timer_id_res, accepted, value, last);
      if (due_events.size() == 0) begin
        note_fault($sformatf("unexpected result kind=%0d id=%0d acc=%0b value=%0h last=%0b",
                             got.kind, got.id, got.acc, got.value, got.last));
      end else begin
        want = due_events.pop_front();
        if (got !== want)
          note_fault($sformatf({"mismatch: exp kind=%0d id=%0d acc=%0b value=%0h last=%0b",
                                " got kind=%0d id=%0d acc=%0b value=%0h last=%0b"},
                               want.kind, want.id, want.acc, want.value, want.last,
                               got.kind, got.id, got.acc, got.value, got.last));
      end
    end
  end

  // Random field values: mostly short timeouts so timers actually fire.
  function automatic logic [VAL_W-1:0] draw_timeout();
    if ($urandom_range(0, 9) < 2) return $urandom;
    return VAL_W'($urandom_range(0, 24));
  endfunction

  function automatic logic [VAL_W-1:0] draw_period();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return '0;
    if (r < 8) return VAL_W'($urandom_range(1, 10));
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests; state carries over from one to the next.
  // ---------------------------------------------------------------------------

  // Fresh block: uptime zero, nothing running, stop of an idle timer.
  task automatic test_queries_after_reset();
    send_command(CMD_READ, '0, '0, '0);
    send_command(CMD_LEFT, 4'd15, '0, '0);
    send_command(CMD_STOP, 4'd3, '0, '0);
  endtask

  // Zero timeout rejected, good start accepted, restart while running rejected.
  task automatic test_start_rules();
    send_command(CMD_START, 4'd0, '0, '0);
    send_command(CMD_START, 4'd0, 32'd1, '0);
    send_command(CMD_START, 4'd0, 32'd5, 32'd3);
    send_command(CMD_LEFT, 4'd0, '0, '0);
  endtask

  // Quiet tick, then the one-shot fires and goes idle.
  task automatic test_one_shot_expiry();
    send_command(CMD_TICK, '0, '0, '0);
    send_command(CMD_TICK, '0, '0, '0);
  endtask

  // All-ones timeout and period: deadline wraps onto the current uptime.
  task automatic test_wrapping_deadline();
    send_command(CMD_START, 4'd15, '1, '1);
    send_command(CMD_LEFT, 4'd15, '0, '0);
  endtask

  // Clear keeps deadlines: timers fire when the uptime next matches.
  task automatic test_clear_keeps_deadlines();
    send_command(CMD_START, 4'd5, 32'd3, 32'd2);
    send_command(CMD_CLEAR, '0, '0, '0);
    send_command(CMD_TICK, '0, '0, '0);
    send_command(CMD_TICK, '0, '0, '0);
  endtask

  task automatic test_unused_codes();
    send_command(CMD_SPARE_LO, 4'd5, '1, '1);
    send_command(CMD_SPARE_HI, 4'd9, '0, '0);
  endtask

  // Periodic timer fires and reloads.
  task automatic test_periodic_reload();
    repeat (4) send_command(CMD_TICK, '0, '0, '0);
  endtask

  task automatic test_stop_replies();
    send_command(CMD_STOP, 4'd5, '0, '0);
    send_command(CMD_STOP, 4'd15, '0, '0);
    send_command(CMD_READ, '0, '0, '0);
  endtask

  // Arm a set of distinct timers on one deadline, then tick through it.
  task automatic run_volley(input int size);
    int order [NT];
    int j;
    int tmp;
    int wait_ticks;
    int reload;
    for (int i = 0; i < NT; i++) order[i] = i;
    for (int i = NT - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    wait_ticks = $urandom_range(1, 12);
    reload     = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    for (int k = 0; k < size; k++) begin
      // stop first so the start is always taken
      send_command(CMD_STOP, ID_W'(order[k]), $urandom, $urandom);
      send_command(CMD_START, ID_W'(order[k]), VAL_W'(wait_ticks), VAL_W'(reload));
    end
    repeat (wait_ticks + 1 + 2 * reload) begin
      if ($urandom_range(0, 6) == 0)
        send_command(CMD_LEFT, ID_W'($urandom), $urandom, $urandom);
      send_command(CMD_TICK, ID_W'($urandom), $urandom, $urandom);
    end
  endtask

  // Every timer expires on the same tick: sixteen results, one last mark, again on each reload tick.
  task automatic test_full_volley();
    steady = 1'b1;
    run_volley(NT);
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic send_random_command();
    int r;
    logic [CMD_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 40)      op = CMD_TICK;
    else if (r < 62) op = CMD_START;
    else if (r < 72) op = CMD_STOP;
    else if (r < 84) op = CMD_LEFT;
    else if (r < 91) op = CMD_READ;
    else if (r < 94) op = CMD_CLEAR;
    else if (r < 96) op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
    else             op = CMD_TICK;
    send_command(op, ID_W'($urandom), draw_timeout(), draw_period());
  endtask

  // Mix of volleys, tick runs and single commands, idle bursts toggled.
  task automatic test_random_mix();
    int goal;
    int pick;
    goal = sent_count + RANDOM_ITEMS;
    while (sent_count < goal) begin
      if ($urandom_range(0, 7) == 0) steady = ~steady;
      pick = $urandom_range(0, 19);
      if (pick == 0) run_volley($urandom_range(1, NT));
      else if (pick == 1)
        repeat ($urandom_range(1, 20)) send_command(CMD_TICK, ID_W'($urandom), $urandom, $urandom);
      else if (pick == 2) wait_drained();
      else send_random_command();
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NT; i++) begin
      armed[i]     = 1'b0;
      due_at[i]    = '0;
      reload_by[i] = '0;
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_queries_after_reset();
    test_start_rules();
    test_one_shot_expiry();
    test_wrapping_deadline();
    test_clear_keeps_deadlines();
    test_unused_codes();
    test_periodic_reload();
    test_stop_replies();
    wait_drained();
    test_full_volley();
    test_random_mix();

    // drain, then give a trailing tick scan time to show any stray result
    wait_drained();
    repeat (4 * NT) @(posedge clk);
    if (due_events.size() != 0)
      note_fault($sformatf("%0d results never arrived", due_events.size()));
    if (fault_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
